// ===== hw/rtl/lpi_pkg.sv =====
// Line/plane intersect: shared widths, codes, pipeline structs and the saturation helper.
// No dependencies.
package lpi_pkg;

	localparam int DotW = 67;   // exact Q35.32 dot product of three terms
	localparam int MagW = 66;   // magnitude of a dot product
	localparam int NumW = 98;   // |top| * |dir|
	localparam int CmpW = 100;  // compare width inside the divider
	localparam int QW   = 34;   // quotient bits kept; anything larger saturates

	typedef logic [1:0] cmd_t;
	localparam cmd_t CmdIsect = 2'd0;
	localparam cmd_t CmdDist  = 2'd1;
	localparam cmd_t CmdAbove = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KindPoint   = 2'd0;
	localparam kind_t KindPar     = 2'd1;
	localparam kind_t KindInPlane = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t RegPx = 3'd0;
	localparam reg_idx_t RegPy = 3'd1;
	localparam reg_idx_t RegPz = 3'd2;
	localparam reg_idx_t RegNx = 3'd3;
	localparam reg_idx_t RegNy = 3'd4;
	localparam reg_idx_t RegNz = 3'd5;

	typedef struct packed {
		cmd_t             cmd;
		logic [2:0][31:0] pt;
		logic [2:0]       dneg;
		logic             sg;
		kind_t            kind;
		logic [31:0]      sdist;
		logic             above;
		logic [2:0]       ovf;
	} side_t;

	typedef struct packed {
		logic [2:0][NumW-1:0] rem;
		logic [2:0][QW-1:0]   quo;
		logic [MagW-1:0]      den;
		side_t                side;
	} div_t;

	function automatic logic [31:0] sat32(input logic [67:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[67:31];
		hi_zeros = ~(|v[67:31]);
		if (hi_ones || hi_zeros) begin
			return v[31:0];
		end
		return v[67] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage

// ===== hw/rtl/lpi_dot.sv =====
// Two-stage exact 3-term dot product: registered products, then registered sum.
// Depends on lpi_pkg.
module lpi_dot (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [32:0]              a0,
	input  logic signed [32:0]              a1,
	input  logic signed [32:0]              a2,
	input  logic signed [31:0]              b0,
	input  logic signed [31:0]              b1,
	input  logic signed [31:0]              b2,
	output logic signed [lpi_pkg::DotW-1:0] dot_s2
);
	import lpi_pkg::*;

	logic signed [64:0] prod0_s1, prod1_s1, prod2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod0_s1 <= a0 * b0;
			prod1_s1 <= a1 * b1;
			prod2_s1 <= a2 * b2;
			dot_s2   <= DotW'(prod0_s1) + DotW'(prod1_s1) + DotW'(prod2_s1);
		end
	end

endmodule

// ===== hw/rtl/lpi_div_cell.sv =====
// One restoring-division cell: settles quotient bit Shift for all three axes.
// Depends on lpi_pkg.
module lpi_div_cell #(
	parameter int unsigned Shift = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  lpi_pkg::div_t din,
	output logic          vld_out,
	output lpi_pkg::div_t dout
);
	import lpi_pkg::*;

	logic [CmpW-1:0] dsh;
	div_t            nxt;

	assign dsh = CmpW'(din.den) << Shift;

	always_comb begin
		nxt = din;
		for (int a = 0; a < 3; a++) begin
			if (CmpW'(din.rem[a]) >= dsh) begin
				nxt.rem[a]        = din.rem[a] - dsh[NumW-1:0];
				nxt.quo[a][Shift] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== hw/rtl/line_plane_intersect.sv =====
// Line/plane intersect top: config registers, dot products, magnitude and
// product stages, divider cell chain, output register. Uses lpi_pkg, lpi_dot, lpi_div_cell.
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, command..dir | item in
//  out     | out_valid, out_stall, hit..above | result out
//  cfg     | cfg_wr_en, cfg_index, cfg_data   | register write
//
// One item per cycle while the output is not stalled; 7 front stages, 34 divider cells, output reg.
// The divider chain, one quotient bit per cell, sets the latency.
// Reset clears the registers to 0 and empties the pipeline.
// A stalled output freezes the whole pipeline; in_stall = out_valid & out_stall.
module line_plane_intersect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  lpi_pkg::reg_idx_t   cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  lpi_pkg::cmd_t       command,
	input  logic signed [31:0]  pt_x,
	input  logic signed [31:0]  pt_y,
	input  logic signed [31:0]  pt_z,
	input  logic signed [31:0]  dir_x,
	input  logic signed [31:0]  dir_y,
	input  logic signed [31:0]  dir_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  hit_x,
	output logic signed [31:0]  hit_y,
	output logic signed [31:0]  hit_z,
	output lpi_pkg::kind_t      hit_kind,
	output logic signed [31:0]  signed_distance,
	output logic                is_above
);
	import lpi_pkg::*;

	logic signed [31:0] px_q, py_q, pz_q, nx_q, ny_q, nz_q;
	logic en;

	assign in_stall = out_valid & out_stall;
	assign en       = ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0; py_q <= '0; pz_q <= '0;
			nx_q <= '0; ny_q <= '0; nz_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				RegPx: px_q <= cfg_data;
				RegPy: py_q <= cfg_data;
				RegPz: pz_q <= cfg_data;
				RegNx: nx_q <= cfg_data;
				RegNy: ny_q <= cfg_data;
				RegNz: nz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: capture and offset from plane point
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	cmd_t                     cmd_s1, cmd_s2, cmd_s3;
	logic [2:0][31:0]         p_s1, p_s2, p_s3, d_s1, d_s2, d_s3;
	logic signed [32:0]       off0_s1, off1_s1, off2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;   vld_s5 <= vld_s4; vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= command;
			p_s1    <= {pt_z, pt_y, pt_x};
			d_s1    <= {dir_z, dir_y, dir_x};
			off0_s1 <= 33'(pt_x) - 33'(px_q);
			off1_s1 <= 33'(pt_y) - 33'(py_q);
			off2_s1 <= 33'(pt_z) - 33'(pz_q);
			cmd_s2  <= cmd_s1; p_s2 <= p_s1; d_s2 <= d_s1;
			cmd_s3  <= cmd_s2; p_s3 <= p_s2; d_s3 <= d_s2;
		end
	end

	logic signed [DotW-1:0] a_s3, b_s3;

	lpi_dot u_dot_off (
		.clk, .en,
		.a0(off0_s1), .a1(off1_s1), .a2(off2_s1),
		.b0(nx_q), .b1(ny_q), .b2(nz_q),
		.dot_s2(a_s3)
	);

	lpi_dot u_dot_dir (
		.clk, .en,
		.a0(33'($signed(d_s1[0]))), .a1(33'($signed(d_s1[1]))), .a2(33'($signed(d_s1[2]))),
		.b0(nx_q), .b1(ny_q), .b2(nz_q),
		.dot_s2(b_s3)
	);

	// s4: magnitudes, kind, distance, above test
	logic signed [DotW-1:0] abs_a, abs_b;
	logic                   a_zero, b_zero;
	side_t                  side_n4, side_s4, side_s5, side_s6;
	logic [MagW-1:0]        tm_s4, bm_s4, bm_s5, bm_s6;
	logic [2:0][31:0]       dmag_n4, dmag_s4;

	always_comb begin
		abs_a  = a_s3[DotW-1] ? -a_s3 : a_s3;
		abs_b  = b_s3[DotW-1] ? -b_s3 : b_s3;
		a_zero = (a_s3 == '0);
		b_zero = (b_s3 == '0);
		side_n4.cmd   = cmd_s3;
		side_n4.pt    = p_s3;
		// top = -A, so top is negative when A is positive
		side_n4.sg    = (~a_s3[DotW-1] & ~a_zero) ^ b_s3[DotW-1];
		side_n4.kind  = b_zero ? (a_zero ? KindInPlane : KindPar) : KindPoint;
		side_n4.sdist = sat32($signed({a_s3[DotW-1], a_s3}) >>> 16);
		side_n4.above = ~a_zero & ~b_zero & (a_s3[DotW-1] == b_s3[DotW-1]);
		side_n4.ovf   = '0;
		for (int a = 0; a < 3; a++) begin
			side_n4.dneg[a] = d_s3[a][31];
			dmag_n4[a]      = d_s3[a][31] ? -d_s3[a] : d_s3[a];
		end
	end

	logic [2:0][63:0]     pl_s5;
	logic [2:0][65:0]     ph_s5;
	logic [2:0][NumW-1:0] num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_n4;
			tm_s4   <= abs_a[MagW-1:0];
			bm_s4   <= abs_b[MagW-1:0];
			dmag_s4 <= dmag_n4;
			// s5: split product of |top| and |dir|
			for (int a = 0; a < 3; a++) begin
				pl_s5[a] <= tm_s4[31:0] * dmag_s4[a];
				ph_s5[a] <= tm_s4[MagW-1:32] * dmag_s4[a];
			end
			side_s5 <= side_s4;
			bm_s5   <= bm_s4;
			// s6: recombine numerators
			for (int a = 0; a < 3; a++) begin
				num_s6[a] <= (NumW'(ph_s5[a]) << 32) + NumW'(pl_s5[a]);
			end
			side_s6 <= side_s5;
			bm_s6   <= bm_s5;
		end
	end

	// s7: quotient range check feeds the cell chain
	div_t            chain_d [QW+1];
	logic            chain_v [QW+1];
	div_t            head_n;
	logic [CmpW-1:0] den_top;

	assign den_top = CmpW'(bm_s6) << QW;

	always_comb begin
		head_n.rem  = num_s6;
		head_n.quo  = '0;
		head_n.den  = bm_s6;
		head_n.side = side_s6;
		for (int a = 0; a < 3; a++) begin
			head_n.side.ovf[a] = (CmpW'(num_s6[a]) >= den_top);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_v[0] <= 1'b0;
		end else if (en) begin
			chain_v[0] <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain_d[0] <= head_n;
		end
	end

	for (genvar gi = 0; gi < QW; gi++) begin : g_cell
		lpi_div_cell #(.Shift(QW - 1 - gi)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(chain_v[gi]), .din(chain_d[gi]),
			.vld_out(chain_v[gi+1]), .dout(chain_d[gi+1])
		);
	end

	// final sign, offset, saturate, and per-command field select
	div_t             last;
	logic [2:0][31:0] hit_n;
	logic [31:0]      dist_n;
	kind_t            kind_n;
	logic             above_n;
	logic             neg;
	logic [35:0]      qx, qs, sum;

	assign last = chain_d[QW];

	always_comb begin
		hit_n   = '0;
		dist_n  = '0;
		kind_n  = KindPoint;
		above_n = 1'b0;
		neg     = 1'b0;
		qx      = '0;
		qs      = '0;
		sum     = '0;
		case (last.side.cmd)
			CmdIsect: begin
				kind_n = last.side.kind;
				for (int a = 0; a < 3; a++) begin
					neg = last.side.sg ^ last.side.dneg[a];
					qx  = {2'b00, last.quo[a]};
					qs  = neg ? -qx : qx;
					sum = qs + {{4{last.side.pt[a][31]}}, last.side.pt[a]};
					case (last.side.kind)
						KindPoint: begin
							if (last.side.ovf[a]) begin
								hit_n[a] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
							end else begin
								hit_n[a] = sat32({{32{sum[35]}}, sum});
							end
						end
						KindInPlane: hit_n[a] = last.side.pt[a];
						default:     hit_n[a] = '0;
					endcase
				end
			end
			CmdDist:  dist_n  = last.side.sdist;
			CmdAbove: above_n = last.side.above;
			default: ;
		endcase
	end

	logic        out_valid_q;
	logic [31:0] hit_x_q, hit_y_q, hit_z_q, dist_q;
	kind_t       kind_q;
	logic        above_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_x_q <= hit_n[0];
			hit_y_q <= hit_n[1];
			hit_z_q <= hit_n[2];
			kind_q  <= kind_n;
			dist_q  <= dist_n;
			above_q <= above_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit_x           = hit_x_q;
	assign hit_y           = hit_y_q;
	assign hit_z           = hit_z_q;
	assign hit_kind        = kind_q;
	assign signed_distance = dist_q;
	assign is_above        = above_q;

	// a held result freezes the whole chain
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_s6) && $stable(chain_v[QW]))
		else $error("pipeline advanced under output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_above |-> hit_kind == KindPoint && signed_distance == 0)
		else $error("above result carries foreign fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_kind == KindPar |-> hit_x == 0 && hit_y == 0 && hit_z == 0)
		else $error("parallel result with nonzero hit");

endmodule
